// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros for the sprite frame sequencer checks
// the expanding scope must provide clk and rst_n
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SFS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfs check failed");

// next-cycle implication
`define SFS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfs check failed");

`endif

// File: rtl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg
// types, codes and the control program of the sprite frame sequencer
// ----------------------------------------------------------------------------
package sfs_pkg;

    localparam int UPC_W = 4;

    // item actions
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_ADVANCE = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // play modes
    localparam logic [1:0] MODE_FORWARD  = 2'd0;
    localparam logic [1:0] MODE_REVERSE  = 2'd1;
    localparam logic [1:0] MODE_PINGPONG = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_FIRST_FRAME = 2'd0;
    localparam logic [1:0] CFG_LAST_FRAME  = 2'd1;
    localparam logic [1:0] CFG_PLAY_MODE   = 2'd2;

    // program addresses
    localparam logic [UPC_W-1:0] PC_ACCEPT   = 4'd0;
    localparam logic [UPC_W-1:0] PC_DISPATCH = 4'd1;
    localparam logic [UPC_W-1:0] PC_LOAD     = 4'd2;
    localparam logic [UPC_W-1:0] PC_ADD      = 4'd3;
    localparam logic [UPC_W-1:0] PC_THR      = 4'd4;
    localparam logic [UPC_W-1:0] PC_TEST     = 4'd5;
    localparam logic [UPC_W-1:0] PC_STEP     = 4'd6;
    localparam logic [UPC_W-1:0] PC_REFETCH  = 4'd7;
    localparam logic [UPC_W-1:0] PC_RESTART  = 4'd8;
    localparam logic [UPC_W-1:0] PC_READ     = 4'd9;
    localparam logic [UPC_W-1:0] PC_EMIT     = 4'd10;

    typedef enum logic [2:0] {
        UOP_NOP,
        UOP_ACCEPT,
        UOP_WRITE,
        UOP_ADD,
        UOP_THR,
        UOP_STEP,
        UOP_RESTART,
        UOP_EMIT
    } uop_t;

    typedef enum logic [1:0] {
        J_NEXT,
        J_ALWAYS,
        J_IF,
        J_DISPATCH
    } jump_t;

    typedef enum logic [1:0] {
        C_NO_ITEM,
        C_BELOW_THR,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        uop_t             uop;
        jump_t            jump;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic [15:0] duration;
        logic [11:0] x;
        logic [11:0] y;
        logic [11:0] w;
        logic [11:0] h;
    } entry_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [7:0]  entry_index;
        logic [15:0] entry_duration;
        logic [11:0] entry_x;
        logic [11:0] entry_y;
        logic [11:0] entry_w;
        logic [11:0] entry_h;
        logic [19:0] elapsed;
    } item_t;

    typedef struct packed {
        logic [7:0]  frame_index;
        logic [11:0] rect_x;
        logic [11:0] rect_y;
        logic [11:0] rect_w;
        logic [11:0] rect_h;
        logic [7:0]  steps_taken;
    } result_t;

    typedef struct packed {
        logic [7:0] first_frame;
        logic [7:0] last_frame;
        logic [1:0] play_mode;
    } cfg_t;

    // sequencer to datapath
    typedef struct packed {
        uop_t uop;
        logic fire;
    } ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic       below_thr;
        logic [1:0] action;
    } stat_t;

    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] pc);
        ucode_t w;
        w = '{uop: UOP_NOP, jump: J_ALWAYS, cond: C_NO_ITEM, target: PC_ACCEPT};
        case (pc)
            PC_ACCEPT:   w = '{UOP_ACCEPT,  J_IF,       C_NO_ITEM,   PC_ACCEPT};
            PC_DISPATCH: w = '{UOP_NOP,     J_DISPATCH, C_NO_ITEM,   PC_READ};
            PC_LOAD:     w = '{UOP_WRITE,   J_ALWAYS,   C_NO_ITEM,   PC_READ};
            PC_ADD:      w = '{UOP_ADD,     J_NEXT,     C_NO_ITEM,   PC_ACCEPT};
            PC_THR:      w = '{UOP_THR,     J_NEXT,     C_NO_ITEM,   PC_ACCEPT};
            PC_TEST:     w = '{UOP_NOP,     J_IF,       C_BELOW_THR, PC_READ};
            PC_STEP:     w = '{UOP_STEP,    J_NEXT,     C_NO_ITEM,   PC_ACCEPT};
            PC_REFETCH:  w = '{UOP_NOP,     J_ALWAYS,   C_NO_ITEM,   PC_THR};
            PC_RESTART:  w = '{UOP_RESTART, J_NEXT,     C_NO_ITEM,   PC_ACCEPT};
            PC_READ:     w = '{UOP_NOP,     J_NEXT,     C_NO_ITEM,   PC_ACCEPT};
            PC_EMIT:     w = '{UOP_EMIT,    J_IF,       C_OUT_BUSY,  PC_EMIT};
            default:     w = '{UOP_NOP,     J_ALWAYS,   C_NO_ITEM,   PC_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/sfs_if.sv
// ----------------------------------------------------------------------------
// sfs channel interfaces
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
interface sfs_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  entry_index;
    logic [15:0] entry_duration;
    logic [11:0] entry_x;
    logic [11:0] entry_y;
    logic [11:0] entry_w;
    logic [11:0] entry_h;
    logic [19:0] elapsed;

    modport source (
        output valid, action, entry_index, entry_duration,
               entry_x, entry_y, entry_w, entry_h, elapsed,
        input  ready
    );
    modport sink (
        input  valid, action, entry_index, entry_duration,
               entry_x, entry_y, entry_w, entry_h, elapsed,
        output ready
    );
endinterface

interface sfs_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  frame_index;
    logic [11:0] rect_x;
    logic [11:0] rect_y;
    logic [11:0] rect_w;
    logic [11:0] rect_h;
    logic [7:0]  steps_taken;

    modport source (
        output valid, frame_index, rect_x, rect_y, rect_w, rect_h, steps_taken,
        input  ready
    );
    modport sink (
        input  valid, frame_index, rect_x, rect_y, rect_w, rect_h, steps_taken,
        output ready
    );
endinterface

// File: rtl/sfs_datapath.sv
// ----------------------------------------------------------------------------
// sfs_datapath
// frame table, time accumulator and frame stepping, driven by control words
// ----------------------------------------------------------------------------
module sfs_datapath #(
    parameter int FRAMES = 256
) (
    input  logic            clk,
    input  logic            rst_n,
    input  sfs_pkg::ctrl_t  ctrl,
    input  sfs_pkg::item_t  item,
    input  sfs_pkg::cfg_t   cfg,
    output sfs_pkg::stat_t  stat,
    output sfs_pkg::result_t res
);
    import sfs_pkg::*;

    localparam int ADDR_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    entry_t mem [FRAMES];

    item_t       item_reg;
    entry_t      rdata_reg;
    logic        oob_reg;
    logic [21:0] acc_reg;
    logic [19:0] thr_reg;
    logic [7:0]  frame_reg;
    logic        back_reg;
    logic [7:0]  steps_reg;

    entry_t      entry_rd;
    logic [15:0] dur_min;
    logic [19:0] thr_next;
    logic [22:0] acc_sum;
    logic [21:0] acc_sat;
    logic [8:0]  up;
    logic        wrap_up;
    logic        wrap_down;
    logic [7:0]  frame_next;
    logic        back_next;
    logic        wr_ok;

    // table port: one write, one registered read of the current frame
    always_ff @(posedge clk)
    begin
        if (ctrl.uop == UOP_WRITE && wr_ok)
        begin
            mem[ADDR_W'(item_reg.entry_index)] <= '{item_reg.entry_duration,
                item_reg.entry_x, item_reg.entry_y, item_reg.entry_w, item_reg.entry_h};
        end
        rdata_reg <= mem[ADDR_W'(frame_reg)];
        oob_reg   <= !({24'd0, frame_reg} < FRAMES);
    end

    assign wr_ok = {24'd0, item_reg.entry_index} < FRAMES;

    // a frame past the table reads as an empty entry
    assign entry_rd = oob_reg ? '0 : rdata_reg;
    assign dur_min  = (entry_rd.duration == 16'd0) ? 16'd1 : entry_rd.duration;
    assign thr_next = {dur_min, 4'd0};

    assign acc_sum = {1'b0, acc_reg} + {3'd0, item_reg.elapsed};
    assign acc_sat = acc_sum[22] ? '1 : acc_sum[21:0];

    assign up        = {1'b0, frame_reg} + 9'd1;
    assign wrap_up   = up > {1'b0, cfg.last_frame};
    assign wrap_down = frame_reg <= cfg.first_frame;

    always_comb
    begin
        frame_next = frame_reg;
        back_next  = back_reg;
        case (cfg.play_mode)
            MODE_FORWARD:
                frame_next = wrap_up ? cfg.first_frame : up[7:0];
            MODE_REVERSE:
                frame_next = wrap_down ? cfg.last_frame : frame_reg - 8'd1;
            MODE_PINGPONG:
            begin
                if (cfg.first_frame == cfg.last_frame)
                begin
                    frame_next = frame_reg;
                end
                else if (back_reg)
                begin
                    if (wrap_down)
                    begin
                        back_next  = 1'b0;
                        frame_next = cfg.first_frame + 8'd1;
                    end
                    else
                    begin
                        frame_next = frame_reg - 8'd1;
                    end
                end
                else if (wrap_up)
                begin
                    back_next  = 1'b1;
                    frame_next = cfg.last_frame - 8'd1;
                end
                else
                begin
                    frame_next = up[7:0];
                end
            end
            default:
                frame_next = frame_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.uop == UOP_ACCEPT && ctrl.fire)
        begin
            item_reg <= item;
        end
        if (ctrl.uop == UOP_THR)
        begin
            thr_reg <= thr_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            frame_reg <= '0;
            back_reg  <= 1'b0;
            steps_reg <= '0;
        end
        else
        begin
            case (ctrl.uop)
                UOP_ACCEPT:
                    if (ctrl.fire)
                    begin
                        steps_reg <= '0;
                    end
                UOP_ADD:
                    acc_reg <= acc_sat;
                UOP_STEP:
                begin
                    acc_reg   <= acc_reg - {2'd0, thr_reg};
                    frame_reg <= frame_next;
                    back_reg  <= back_next;
                    if (steps_reg != 8'hFF)
                    begin
                        steps_reg <= steps_reg + 8'd1;
                    end
                end
                UOP_RESTART:
                begin
                    acc_reg   <= '0;
                    frame_reg <= cfg.first_frame;
                    back_reg  <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign stat.below_thr = acc_reg < {2'd0, thr_reg};
    assign stat.action    = item_reg.action;

    assign res = '{frame_index: frame_reg, rect_x: entry_rd.x, rect_y: entry_rd.y,
                   rect_w: entry_rd.w, rect_h: entry_rd.h, steps_taken: steps_reg};

endmodule

// File: rtl/sprite_frame_sequencer_top.sv
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_top
// sprite animation frame sequencer with a microcoded control loop
// ----------------------------------------------------------------------------
// Holds a table of FRAMES animation entries (duration in ms and a sheet
// rectangle) and returns one result item for every input item. A small
// program in a constant table steps a plain datapath; the frame table has
// one write port and one registered read port, and every frame step goes
// through that read port. After the accept and dispatch steps, a load writes
// the table, a restart returns to the first frame, and an advance adds the
// elapsed time, then repeats threshold load, compare, step and a table read
// of the new frame while the time reaches the threshold; each item ends with
// a read, the emit and a return step. The next item is taken while a result
// still waits in the output register. Entries read before they are written
// give undefined rectangles and durations.
module sprite_frame_sequencer_top #(
    parameter int FRAMES = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    sfs_item_if.sink   item_ch,
    sfs_result_if.source result_ch,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import sfs_pkg::*;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    ucode_t           uw;
    cfg_t             cfg_reg;
    logic             out_valid_reg;
    result_t          out_reg;
    logic             cond;
    logic             out_busy;
    ctrl_t            ctrl;
    stat_t            stat;
    item_t            item;
    result_t          res;

    assign uw       = ucode_rom(upc_reg);
    assign out_busy = out_valid_reg && !result_ch.ready;

    always_comb
    begin
        unique case (uw.cond)
            C_NO_ITEM:   cond = !item_ch.valid;
            C_BELOW_THR: cond = stat.below_thr;
            C_OUT_BUSY:  cond = out_busy;
            default:     cond = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (uw.jump)
            J_NEXT:   upc_next = upc_reg + UPC_W'(1);
            J_ALWAYS: upc_next = uw.target;
            J_IF:     upc_next = cond ? uw.target : upc_reg + UPC_W'(1);
            J_DISPATCH:
                unique case (stat.action)
                    ACT_LOAD:    upc_next = PC_LOAD;
                    ACT_ADVANCE: upc_next = PC_ADD;
                    ACT_RESTART: upc_next = PC_RESTART;
                    default:     upc_next = PC_READ;
                endcase
            default:  upc_next = PC_ACCEPT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= PC_ACCEPT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIRST_FRAME: cfg_reg.first_frame <= cfg_data;
                CFG_LAST_FRAME:  cfg_reg.last_frame  <= cfg_data;
                CFG_PLAY_MODE:   cfg_reg.play_mode   <= cfg_data[1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign item_ch.ready = (uw.uop == UOP_ACCEPT);

    assign item = '{action: item_ch.action, entry_index: item_ch.entry_index,
                    entry_duration: item_ch.entry_duration, entry_x: item_ch.entry_x,
                    entry_y: item_ch.entry_y, entry_w: item_ch.entry_w,
                    entry_h: item_ch.entry_h, elapsed: item_ch.elapsed};

    assign ctrl.uop  = uw.uop;
    assign ctrl.fire = (uw.uop == UOP_ACCEPT) ? item_ch.valid : !out_busy;

    sfs_datapath #(
        .FRAMES (FRAMES)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .item  (item),
        .cfg   (cfg_reg),
        .stat  (stat),
        .res   (res)
    );

    // output register parts the result side from the sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (uw.uop == UOP_EMIT && !out_busy)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (uw.uop == UOP_EMIT && !out_busy)
        begin
            out_reg <= res;
        end
    end

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.frame_index = out_reg.frame_index;
    assign result_ch.rect_x      = out_reg.rect_x;
    assign result_ch.rect_y      = out_reg.rect_y;
    assign result_ch.rect_w      = out_reg.rect_w;
    assign result_ch.rect_h      = out_reg.rect_h;
    assign result_ch.steps_taken = out_reg.steps_taken;

endmodule

// File: rtl/sfs_checker.sv
// ----------------------------------------------------------------------------
// sfs_checker
// port-level checks on the sprite frame sequencer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sfs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input logic       result_valid,
    input logic       result_ready,
    input logic [7:0] result_frame_index,
    input logic [7:0] result_steps_taken
);

    // a stalled result keeps its place
    `SFS_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid)

    `SFS_ASSERT_NEXT(a_result_stable, result_valid && !result_ready,
        $stable(result_frame_index) && $stable(result_steps_taken))

    // one item at a time: no back-to-back accepts
    `SFS_ASSERT_NEXT(a_single_item, item_valid && item_ready, !item_ready)

    // a result never appears the cycle after an item is taken
    `SFS_ASSERT_NEXT(a_min_latency, item_valid && item_ready, !$rose(result_valid))

endmodule

bind sprite_frame_sequencer_top sfs_checker u_sfs_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .item_valid         (item_ch.valid),
    .item_ready         (item_ch.ready),
    .result_valid       (result_ch.valid),
    .result_ready       (result_ch.ready),
    .result_frame_index (result_ch.frame_index),
    .result_steps_taken (result_ch.steps_taken)
);
